>>> design/sisplit_pkg.sv
// Shared types and constants for the sub-step interval splitter.
// Used by the controller, the datapath and the top level.
package sisplit_pkg;

	localparam int TIME_BITS = 64;
	localparam int FRAC_BITS = 32;
	localparam int DIVN_BITS = 2 * FRAC_BITS + 1;
	localparam int DIVD_BITS = FRAC_BITS + 1;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [FRAC_BITS:0] FONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [2*FRAC_BITS:0] FHALF = (2*FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

	localparam logic [CFG_IDX_BITS-1:0] REG_SHRINK_MODE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHRINK_FACTOR = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_COUNT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_STEP_LEN = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_LIMIT = 3'd4;

	typedef enum logic [1:0] {
		MUL_POW = 2'd0,
		MUL_HI = 2'd1,
		MUL_LO = 2'd2
	} mul_sel_t;

	typedef enum logic [1:0] {
		F_HOLD = 2'd0,
		F_ONE = 2'd1,
		F_DIV = 2'd2,
		F_FREE = 2'd3
	} f_sel_t;

	typedef struct packed {
		logic load;
		logic div_go;
		logic div_geo;
		logic dt_set;
		logic e_lin;
		logic mul_go;
		mul_sel_t mul_sel;
		logic pow_upd;
		logic pow_init;
		logic den_set;
		logic k_init;
		logic k_inc;
		f_sel_t f_sel;
		logic acc_set;
		logic e_scale;
		logic emit;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic linear;
		logic n_zero;
		logic k_lt_n;
		logic k_eq_n;
		logic num_ge_den;
		logic f_one;
		logic div_busy;
		logic cur_lt_stop;
		logic k_le_lim;
		logic e_gt_cur;
		logic step_short;
		logic out_free;
	} status_t;

endpackage

>>> design/sisplit_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on sisplit_pkg for operand widths.
module sisplit_div (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [sisplit_pkg::DIVN_BITS-1:0] dividend,
	input logic [sisplit_pkg::DIVD_BITS-1:0] divisor,
	output logic busy,
	output logic [sisplit_pkg::DIVN_BITS-1:0] quot
);
	import sisplit_pkg::*;

	localparam int CNT_BITS = $clog2(DIVN_BITS + 1);

	logic [DIVN_BITS-1:0] q_q;
	logic [DIVD_BITS:0] rem_q;
	logic [DIVD_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic [DIVD_BITS:0] rem_sh;
	logic take;

	assign rem_sh = {rem_q[DIVD_BITS-1:0], q_q[DIVN_BITS-1]};
	assign take = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_BITS'(DIVN_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, dvs_q} : rem_sh;
			q_q <= {q_q[DIVN_BITS-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quot = q_q;
endmodule

>>> design/sisplit_dp.sv
// Datapath: configuration registers, interval work registers, shared multiplier,
// pending and output registers. Depends on sisplit_pkg and sisplit_div.
module sisplit_dp #(
	parameter int MAX_FIXED_STEPS = 32,
	parameter int MAX_FREE_STEPS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sisplit_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [sisplit_pkg::TIME_BITS-1:0] cfg_data,
	input logic [2*sisplit_pkg::TIME_BITS-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	output logic [2*sisplit_pkg::TIME_BITS-1:0] m_tdata,
	output logic m_tlast,
	input sisplit_pkg::cmd_t cmd,
	output sisplit_pkg::status_t sts
);
	import sisplit_pkg::*;

	localparam int TB = TIME_BITS;
	localparam int FB = FRAC_BITS;

	logic mode_q;
	logic [15:0] sf_q;
	logic [5:0] cnt_q;
	logic [TB-1:0] minlen_q;
	logic [6:0] limcfg_q;

	logic [TB-1:0] start_q, stop_q, len_q, cur_q, acc_q, e_q, dt_q, pst_q, psp_q;
	logic [FB-1:0] pow_q;
	logic [FB:0] den_q, f_q;
	logic [5:0] n_q;
	logic [6:0] lim_q, k_q;
	logic [2*FB-1:0] prod_q;
	logic pv_q;
	logic ov_q;
	logic [TB-1:0] os_q, oe_q;
	logic ol_q;

	logic [FB-1:0] r;
	logic [FB:0] num;
	logic [FB-1:0] opa, opb;
	logic [2*FB:0] prod_rnd;
	logic [TB-1:0] in_start, in_stop;
	logic [DIVN_BITS-1:0] dvd, quot;
	logic [DIVD_BITS-1:0] dvs;
	logic div_busy;
	logic [5:0] n_eff;

	assign in_start = s_tdata[TB-1:0];
	assign in_stop = s_tdata[2*TB-1:TB];
	assign r = {sf_q, {(FB-16){1'b0}}};
	assign num = FONE - {1'b0, pow_q};
	assign prod_rnd = {1'b0, prod_q} + FHALF;
	assign n_eff = (n_q == 6'd0) ? 6'd1 : n_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_POW: begin
				opa = pow_q;
				opb = r;
			end
			MUL_HI: begin
				opa = len_q[2*FB-1:FB];
				opb = f_q[FB-1:0];
			end
			MUL_LO: begin
				opa = len_q[FB-1:0];
				opb = f_q[FB-1:0];
			end
			default: begin
				opa = pow_q;
				opb = r;
			end
		endcase
	end

	assign dvd = cmd.div_geo ? ({num, {FB{1'b0}}} + {{(FB+1){1'b0}}, den_q[FB:1]})
		: {1'b0, len_q};
	assign dvs = cmd.div_geo ? den_q : {{(DIVD_BITS-6){1'b0}}, n_eff};

	sisplit_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(cmd.div_go),
		.dividend(dvd),
		.divisor(dvs),
		.busy(div_busy),
		.quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			sf_q <= 16'd32768;
			cnt_q <= 6'd1;
			minlen_q <= '0;
			limcfg_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHRINK_MODE: mode_q <= cfg_data[0];
				REG_SHRINK_FACTOR: sf_q <= cfg_data[15:0];
				REG_STEP_COUNT: cnt_q <= cfg_data[5:0];
				REG_MIN_STEP_LEN: minlen_q <= cfg_data;
				REG_STEP_LIMIT: limcfg_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.load || cmd.fin)
				pv_q <= 1'b0;
			else if (cmd.emit)
				pv_q <= 1'b1;
			if ((cmd.emit && pv_q) || cmd.fin)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= in_start;
			stop_q <= in_stop;
			len_q <= in_stop - in_start;
			cur_q <= in_start;
			n_q <= (cnt_q > 6'(MAX_FIXED_STEPS)) ? 6'(MAX_FIXED_STEPS) : cnt_q;
			lim_q <= (limcfg_q > 7'(MAX_FREE_STEPS)) ? 7'(MAX_FREE_STEPS) : limcfg_q;
		end
		if (cmd.mul_go)
			prod_q <= opa * opb;
		if (cmd.pow_init)
			pow_q <= r;
		else if (cmd.pow_upd)
			pow_q <= prod_rnd[2*FB-1:FB];
		if (cmd.den_set)
			den_q <= num;
		if (cmd.k_init)
			k_q <= 7'd1;
		else if (cmd.k_inc)
			k_q <= k_q + 7'd1;
		case (cmd.f_sel)
			F_ONE: f_q <= FONE;
			F_DIV: f_q <= quot[FB:0];
			F_FREE: f_q <= num;
			default: ;
		endcase
		if (cmd.acc_set)
			acc_q <= prod_q;
		if (cmd.dt_set)
			dt_q <= (quot[TB-1:0] == '0) ? TB'(1) : quot[TB-1:0];
		if (cmd.e_lin)
			e_q <= ((stop_q - cur_q) <= dt_q) ? stop_q : cur_q + dt_q;
		else if (cmd.e_scale)
			e_q <= f_q[FB] ? stop_q
				: start_q + acc_q + {{(TB-FB-1){1'b0}}, prod_rnd[2*FB:FB]};
		if (cmd.emit) begin
			pst_q <= cur_q;
			psp_q <= e_q;
			cur_q <= e_q;
			if (pv_q) begin
				os_q <= pst_q;
				oe_q <= psp_q;
				ol_q <= 1'b0;
			end
		end
		if (cmd.fin) begin
			os_q <= pv_q ? pst_q : cur_q;
			oe_q <= stop_q;
			ol_q <= 1'b1;
		end
	end

	assign sts.empty = start_q >= stop_q;
	assign sts.linear = !mode_q || (sf_q == 16'd0);
	assign sts.n_zero = n_q == 6'd0;
	assign sts.k_lt_n = k_q < {1'b0, n_q};
	assign sts.k_eq_n = k_q == {1'b0, n_q};
	assign sts.num_ge_den = num >= den_q;
	assign sts.f_one = f_q[FB];
	assign sts.div_busy = div_busy;
	assign sts.cur_lt_stop = cur_q < stop_q;
	assign sts.k_le_lim = k_q <= lim_q;
	assign sts.e_gt_cur = e_q > cur_q;
	assign sts.step_short = (e_q - cur_q) < minlen_q;
	assign sts.out_free = !ov_q || m_tready;

	assign m_tvalid = ov_q;
	assign m_tdata = {oe_q, os_q};
	assign m_tlast = ol_q;
endmodule

>>> design/sisplit_ctrl.sv
// Controller state machine sequencing the datapath for all three modes.
// Depends on sisplit_pkg for command and status structs.
module sisplit_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input sisplit_pkg::status_t sts,
	output sisplit_pkg::cmd_t cmd
);
	import sisplit_pkg::*;

	typedef enum logic [19:0] {
		S_IDLE  = 20'h00001,
		S_SETUP = 20'h00002,
		S_LDIV  = 20'h00004,
		S_LSTEP = 20'h00008,
		S_LEMIT = 20'h00010,
		S_GPOW  = 20'h00020,
		S_GPOWU = 20'h00040,
		S_GK    = 20'h00080,
		S_GDIV  = 20'h00100,
		S_GEMIT = 20'h00200,
		S_GNEXT = 20'h00400,
		S_FLOOP = 20'h00800,
		S_FEMIT = 20'h01000,
		S_FPOW  = 20'h02000,
		S_FPOWF = 20'h04000,
		S_FCHK  = 20'h08000,
		S_SC0   = 20'h10000,
		S_SC1   = 20'h20000,
		S_SC2   = 20'h40000,
		S_FIN   = 20'h80000
	} state_t;

	typedef enum logic [1:0] {
		PH_GEO = 2'd0,
		PH_FA = 2'd1,
		PH_FB = 2'd2
	} phase_t;

	state_t state_q, state_d;
	phase_t ph_q, ph_d;
	state_t ret_st;

	always_comb begin
		case (ph_q)
			PH_GEO: ret_st = S_GEMIT;
			PH_FA: ret_st = S_FEMIT;
			PH_FB: ret_st = S_FCHK;
			default: ret_st = S_GEMIT;
		endcase
	end

	always_comb begin
		state_d = state_q;
		ph_d = ph_q;
		cmd = '0;
		cmd.mul_sel = MUL_POW;
		cmd.f_sel = F_HOLD;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				if (sts.empty)
					state_d = S_IDLE;
				else if (sts.linear) begin
					cmd.div_go = 1'b1;
					state_d = S_LDIV;
				end else begin
					cmd.pow_init = 1'b1;
					cmd.k_init = 1'b1;
					state_d = sts.n_zero ? S_FLOOP : S_GPOW;
				end
			end
			S_LDIV: begin
				if (!sts.div_busy) begin
					cmd.dt_set = 1'b1;
					state_d = S_LSTEP;
				end
			end
			S_LSTEP: begin
				if (sts.cur_lt_stop) begin
					cmd.e_lin = 1'b1;
					state_d = S_LEMIT;
				end else
					state_d = S_FIN;
			end
			S_LEMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_LSTEP;
				end
			end
			S_GPOW: begin
				if (sts.k_lt_n) begin
					cmd.mul_go = 1'b1;
					state_d = S_GPOWU;
				end else begin
					cmd.den_set = 1'b1;
					cmd.pow_init = 1'b1;
					cmd.k_init = 1'b1;
					state_d = S_GK;
				end
			end
			S_GPOWU: begin
				cmd.pow_upd = 1'b1;
				cmd.k_inc = 1'b1;
				state_d = S_GPOW;
			end
			S_GK: begin
				ph_d = PH_GEO;
				if (sts.k_eq_n || sts.num_ge_den) begin
					cmd.f_sel = F_ONE;
					state_d = S_SC0;
				end else begin
					cmd.div_go = 1'b1;
					cmd.div_geo = 1'b1;
					state_d = S_GDIV;
				end
			end
			S_GDIV: begin
				if (!sts.div_busy) begin
					cmd.f_sel = F_DIV;
					state_d = S_SC0;
				end
			end
			S_GEMIT: begin
				if (sts.out_free) begin
					cmd.emit = sts.e_gt_cur;
					cmd.mul_go = 1'b1;
					state_d = S_GNEXT;
				end
			end
			S_GNEXT: begin
				cmd.pow_upd = 1'b1;
				cmd.k_inc = 1'b1;
				state_d = sts.k_eq_n ? S_FIN : S_GK;
			end
			S_FLOOP: begin
				if (sts.k_le_lim && sts.cur_lt_stop) begin
					cmd.f_sel = F_FREE;
					ph_d = PH_FA;
					state_d = S_SC0;
				end else
					state_d = S_FIN;
			end
			S_FEMIT: begin
				if (!sts.e_gt_cur)
					state_d = S_FIN;
				else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.mul_go = 1'b1;
					state_d = S_FPOW;
				end
			end
			S_FPOW: begin
				cmd.pow_upd = 1'b1;
				state_d = S_FPOWF;
			end
			S_FPOWF: begin
				cmd.f_sel = F_FREE;
				ph_d = PH_FB;
				state_d = S_SC0;
			end
			S_FCHK: begin
				if (sts.step_short)
					state_d = S_FIN;
				else begin
					cmd.k_inc = 1'b1;
					state_d = S_FLOOP;
				end
			end
			S_SC0: begin
				if (sts.f_one) begin
					cmd.e_scale = 1'b1;
					state_d = ret_st;
				end else begin
					cmd.mul_go = 1'b1;
					cmd.mul_sel = MUL_HI;
					state_d = S_SC1;
				end
			end
			S_SC1: begin
				cmd.acc_set = 1'b1;
				cmd.mul_go = 1'b1;
				cmd.mul_sel = MUL_LO;
				state_d = S_SC2;
			end
			S_SC2: begin
				cmd.e_scale = 1'b1;
				state_d = ret_st;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= PH_GEO;
		end else begin
			state_q <= state_d;
			ph_q <= ph_d;
		end
	end
endmodule

>>> design/substep_interval_splitter_unit.sv
// Splits each incoming interval [start, stop) into contiguous sub-intervals, one item at a time.
// One interval occupies the block until its last sub-step beat has been handed to the output
// register. Linear mode runs the serial divider once and then steps through the sub-steps.
// Geometric fixed-count mode first computes the ratio powers (N-1 of them) and then may run
// the 65-step restoring divider for each sub-step. Free-shrink mode computes each sub-step
// through the shared 32x32 multiplier. An empty interval gives no beat. The output side can
// stall the block through back-pressure.
module substep_interval_splitter_unit #(
	parameter int MAX_FIXED_STEPS = 32,
	parameter int MAX_FREE_STEPS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sisplit_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [sisplit_pkg::TIME_BITS-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// interval_start [63:0], interval_stop [127:64]
	input logic [2*sisplit_pkg::TIME_BITS-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// sub_start [63:0], sub_stop [127:64]
	output logic [2*sisplit_pkg::TIME_BITS-1:0] m_tdata,
	output logic m_tlast
);
	import sisplit_pkg::*;

	cmd_t cmd;
	status_t sts;

	sisplit_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	sisplit_dp #(
		.MAX_FIXED_STEPS(MAX_FIXED_STEPS),
		.MAX_FREE_STEPS(MAX_FREE_STEPS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cmd(cmd),
		.sts(sts)
	);
endmodule
